FILE: rtl/pl0ts_pkg.sv
// Shared types, token codes, keyword table and decode helpers of the PL/0 token scanner.
package pl0ts_pkg;

  // Defaults of the top-level limits.
  localparam int NAME_CHARS_DEF   = 11;
  localparam int NUMBER_DIGITS_DEF = 5;

  // Token kinds.
  localparam logic [5:0] K_IDENT    = 6'd0;
  localparam logic [5:0] K_NUMBER   = 6'd1;
  localparam logic [5:0] K_KEYWORD0 = 6'd2;
  localparam logic [5:0] K_EQL      = 6'd14;
  localparam logic [5:0] K_NEQ      = 6'd15;
  localparam logic [5:0] K_LSS      = 6'd16;
  localparam logic [5:0] K_LEQ      = 6'd17;
  localparam logic [5:0] K_GTR      = 6'd18;
  localparam logic [5:0] K_GEQ      = 6'd19;
  localparam logic [5:0] K_MOD      = 6'd20;
  localparam logic [5:0] K_MUL      = 6'd21;
  localparam logic [5:0] K_DIV      = 6'd22;
  localparam logic [5:0] K_ADD      = 6'd23;
  localparam logic [5:0] K_SUB      = 6'd24;
  localparam logic [5:0] K_LPAREN   = 6'd25;
  localparam logic [5:0] K_RPAREN   = 6'd26;
  localparam logic [5:0] K_COMMA    = 6'd27;
  localparam logic [5:0] K_PERIOD   = 6'd28;
  localparam logic [5:0] K_SEMI     = 6'd29;
  localparam logic [5:0] K_ASSIGN   = 6'd30;
  localparam logic [5:0] K_END      = 6'd31;
  localparam logic [5:0] K_ERROR    = 6'd32;

  // Error codes.
  localparam logic [2:0] E_NONE        = 3'd0;
  localparam logic [2:0] E_BAD_SYMBOL  = 3'd1;
  localparam logic [2:0] E_BAD_IDENT   = 3'd2;
  localparam logic [2:0] E_NUM_LONG    = 3'd3;
  localparam logic [2:0] E_IDENT_LONG  = 3'd4;

  // Keywords, packed with the first character in the lowest byte.
  localparam int KW_COUNT = 12;
  localparam logic [71:0] KW_TEXT [KW_COUNT] = '{
    72'("tsnoc"), 72'("rav"), 72'("erudecorp"), 72'("od"), 72'("do"), 72'("elihw"),
    72'("nehw"), 72'("odesle"), 72'("llac"), 72'("etirw"), 72'("daer"), 72'("ddo")
  };
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd5, 4'd3, 4'd9, 4'd2, 4'd2, 4'd5, 4'd4, 4'd6, 4'd4, 4'd5, 4'd4, 4'd3
  };

  typedef enum logic [2:0] {
    M_IDLE, M_WORD, M_NUM, M_OP, M_COMMENT, M_ERROR
  } mode_t;

  typedef enum logic [2:0] {
    P_NONE, P_LT, P_GT, P_BANG, P_EQ, P_COLON, P_SLASH
  } pend_t;

  typedef struct packed {
    logic [5:0]  kind;
    logic [16:0] num;
    logic [63:0] lo;
    logic [23:0] hi;
    logic [3:0]  len;
    logic [2:0]  err;
  } tok_t;

  // Outcome of the first character of a new token.
  typedef struct packed {
    mode_t mode;
    pend_t pend;
    logic  emit;
    tok_t  tok;
  } start_t;

  function automatic tok_t tok_kind(input logic [5:0] k);
    tok_t t;
    t = '0;
    t.kind = k;
    return t;
  endfunction

  function automatic tok_t tok_error(input logic [2:0] e);
    tok_t t;
    t = '0;
    t.kind = K_ERROR;
    t.err = e;
    return t;
  endfunction

  function automatic tok_t tok_number(input logic [16:0] v);
    tok_t t;
    t = '0;
    t.kind = K_NUMBER;
    t.num = v;
    return t;
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c inside {["a":"z"], ["A":"Z"]});
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c inside {["0":"9"]});
  endfunction

  function automatic logic is_control(input logic [7:0] c);
    return (c inside {[8'd0:8'd31], 8'd127});
  endfunction

  // A pending operator that is not completed by a second character.
  function automatic tok_t op_single(input pend_t p);
    tok_t t;
    case (p)
      P_LT:    t = tok_kind(K_LSS);
      P_GT:    t = tok_kind(K_GTR);
      P_SLASH: t = tok_kind(K_DIV);
      default: t = tok_error(E_BAD_SYMBOL);
    endcase
    return t;
  endfunction

  // Classifies the first character of a token. Letters and digits are
  // handled by the caller, which loads the word or number registers.
  function automatic start_t start_decode(input logic [7:0] c);
    start_t s;
    s.mode = M_IDLE;
    s.pend = P_NONE;
    s.emit = 1'b0;
    s.tok  = '0;
    if (is_control(c) || c == " ") begin
      s.mode = M_IDLE;
    end else if (is_letter(c)) begin
      s.mode = M_WORD;
    end else if (is_digit(c)) begin
      s.mode = M_NUM;
    end else begin
      s.emit = 1'b1;
      case (c)
        "<": begin s.pend = P_LT;    s.emit = 1'b0; end
        ">": begin s.pend = P_GT;    s.emit = 1'b0; end
        "!": begin s.pend = P_BANG;  s.emit = 1'b0; end
        "=": begin s.pend = P_EQ;    s.emit = 1'b0; end
        ":": begin s.pend = P_COLON; s.emit = 1'b0; end
        "/": begin s.pend = P_SLASH; s.emit = 1'b0; end
        "%": s.tok = tok_kind(K_MOD);
        "*": s.tok = tok_kind(K_MUL);
        "+": s.tok = tok_kind(K_ADD);
        "-": s.tok = tok_kind(K_SUB);
        "(": s.tok = tok_kind(K_LPAREN);
        ")": s.tok = tok_kind(K_RPAREN);
        ",": s.tok = tok_kind(K_COMMA);
        ".": s.tok = tok_kind(K_PERIOD);
        ";": s.tok = tok_kind(K_SEMI);
        default: begin
          s.tok  = tok_error(E_BAD_SYMBOL);
          s.mode = M_ERROR;
        end
      endcase
      if (s.pend != P_NONE) begin
        s.mode = M_OP;
      end
    end
    return s;
  endfunction

endpackage

FILE: rtl/pl0ts_ifs.sv
// Request channels of the PL/0 token scanner: source characters in, tokens out.
interface pl0ts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_text;

  modport source (output valid, output char_code, output end_of_text, input ready);
  modport sink (input valid, input char_code, input end_of_text, output ready);
endinterface

interface pl0ts_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  token_kind;
  logic [16:0] number_value;
  logic [63:0] name_low;
  logic [23:0] name_high;
  logic [3:0]  name_length;
  logic [2:0]  error_code;
  logic        last_of_run;

  modport source (output valid, output token_kind, output number_value, output name_low,
                  output name_high, output name_length, output error_code,
                  output last_of_run, input ready);
  modport sink (input valid, input token_kind, input number_value, input name_low,
                input name_high, input name_length, input error_code,
                input last_of_run, output ready);
endinterface

FILE: rtl/pl0_token_scanner.sv
// Top level of the PL/0 token scanner: one character per request in, tokens out.
//
// Usage: each request on in_ch carries one source character and an end_of_text
// flag that marks the last character of the text. Each request on out_ch carries
// one token: identifier, number, keyword, operator, error or end. A character
// causes zero to three tokens; last_of_run marks the last token of a character.
// The scanner state and all tokens of a character are computed in the cycle
// the character is accepted and land in a three-entry result register, so the
// first token shows on out_ch in the cycle after acceptance.
// Throughput: one character per cycle while each character causes at most one
// token and out_ch.ready is high; the tokens of a character leave through the
// single output port one token per cycle while out_ch.ready is high.
// in_ch.ready stays high while the last pending token leaves, so a stalled
// receiver only holds back input once the result register is occupied.
// Reset (rst_n low, synchronous) empties the result register and returns the
// scanner to idle with no word, number or operator pending.
// After an error token, characters are dropped until end_of_text, which then
// only produces the end token.
module pl0_token_scanner #(
  parameter int MAX_NAME_CHARS    = pl0ts_pkg::NAME_CHARS_DEF,
  parameter int MAX_NUMBER_DIGITS = pl0ts_pkg::NUMBER_DIGITS_DEF
) (
  input logic          clk,
  input logic          rst_n,
  pl0ts_in_if.sink     in_ch,
  pl0ts_out_if.source  out_ch
);
  import pl0ts_pkg::*;

  localparam int DCW = $clog2(MAX_NUMBER_DIGITS + 1);

  typedef logic [MAX_NAME_CHARS-1:0][7:0] wbuf_t;

  // Scanner state.
  mode_t            mode_r, mode_nxt;
  pend_t            pend_r, pend_nxt;
  logic [3:0]       len_r, len_nxt;
  logic [16:0]      acc_r, acc_nxt;
  logic [DCW-1:0]   dcnt_r, dcnt_nxt;
  wbuf_t            wbuf_r, wbuf_nxt;

  // Result register: up to three tokens per character, read out in order.
  tok_t             slot_r [3];
  tok_t             tok_nxt [3];
  logic [1:0]       num_r, ntok_nxt;
  logic [1:0]       rd_r;

  logic             in_fire, out_fire, out_last;

  // Builds the token of a finished word: keyword if the text matches one,
  // otherwise an identifier with its characters packed first-in-lowest-byte.
  function automatic tok_t word_tok(input wbuf_t b, input logic [3:0] n);
    logic [87:0] name;
    tok_t        t;
    name = '0;
    for (int i = 0; i < MAX_NAME_CHARS; i++) begin
      if (4'(i) < n) begin
        name[8*i +: 8] = b[i];
      end
    end
    t = '0;
    t.kind = K_IDENT;
    t.lo   = name[63:0];
    t.hi   = name[87:64];
    t.len  = n;
    // Bytes past the word length are zero, so a whole-word compare works.
    for (int k = 0; k < KW_COUNT; k++) begin
      if (n == KW_LEN[k] && name[71:0] == KW_TEXT[k]) begin
        t = '0;
        t.kind = 6'(K_KEYWORD0 + k);
      end
    end
    return t;
  endfunction

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign out_last = (rd_r + 2'd1) == num_r;

  // Next state: one full scanner step for the presented character, including
  // the list of tokens it causes. It is only committed when the request is
  // accepted.
  always_comb begin
    logic [7:0] c;
    logic       eot;
    logic       do_start;
    logic [1:0] n;
    start_t     sd;
    tok_t       t;

    c        = in_ch.char_code;
    eot      = in_ch.end_of_text;
    do_start = 1'b0;
    n        = 2'd0;
    sd       = start_decode(c);
    t        = '0;

    mode_nxt = mode_r;
    pend_nxt = pend_r;
    len_nxt  = len_r;
    acc_nxt  = acc_r;
    dcnt_nxt = dcnt_r;
    wbuf_nxt = wbuf_r;
    for (int i = 0; i < 3; i++) begin
      tok_nxt[i] = '0;
    end

    case (mode_r)
      M_ERROR: begin
      end
      M_COMMENT: begin
        if (is_control(c)) begin
          mode_nxt = M_IDLE;
        end
      end
      M_WORD: begin
        if (is_letter(c) || is_digit(c)) begin
          if (len_r < 4'(MAX_NAME_CHARS)) begin
            for (int i = 0; i < MAX_NAME_CHARS; i++) begin
              if (len_r == 4'(i)) begin
                wbuf_nxt[i] = c;
              end
            end
            len_nxt = len_r + 4'd1;
          end else begin
            tok_nxt[n] = tok_error(E_IDENT_LONG);
            n = n + 2'd1;
            mode_nxt = M_ERROR;
            len_nxt = '0;
          end
        end else begin
          tok_nxt[n] = word_tok(wbuf_r, len_r);
          n = n + 2'd1;
          do_start = 1'b1;
        end
      end
      M_NUM: begin
        if (is_digit(c)) begin
          if (dcnt_r < DCW'(MAX_NUMBER_DIGITS)) begin
            acc_nxt  = 17'(acc_r * 17'd10 + {13'd0, c[3:0]});
            dcnt_nxt = dcnt_r + DCW'(1);
          end else begin
            tok_nxt[n] = tok_error(E_NUM_LONG);
            n = n + 2'd1;
            mode_nxt = M_ERROR;
            acc_nxt  = '0;
            dcnt_nxt = '0;
          end
        end else if (is_letter(c)) begin
          tok_nxt[n] = tok_error(E_BAD_IDENT);
          n = n + 2'd1;
          mode_nxt = M_ERROR;
          acc_nxt  = '0;
          dcnt_nxt = '0;
        end else begin
          tok_nxt[n] = tok_number(acc_r);
          n = n + 2'd1;
          do_start = 1'b1;
        end
      end
      M_OP: begin
        if (c == "=" && pend_r != P_NONE && pend_r != P_SLASH) begin
          case (pend_r)
            P_LT:    tok_nxt[n] = tok_kind(K_LEQ);
            P_GT:    tok_nxt[n] = tok_kind(K_GEQ);
            P_BANG:  tok_nxt[n] = tok_kind(K_NEQ);
            P_EQ:    tok_nxt[n] = tok_kind(K_EQL);
            default: tok_nxt[n] = tok_kind(K_ASSIGN);
          endcase
          n = n + 2'd1;
          pend_nxt = P_NONE;
          mode_nxt = M_IDLE;
        end else if (c == "/" && pend_r == P_SLASH) begin
          pend_nxt = P_NONE;
          mode_nxt = M_COMMENT;
        end else begin
          t = op_single(pend_r);
          tok_nxt[n] = t;
          n = n + 2'd1;
          pend_nxt = P_NONE;
          if (t.kind == K_ERROR) begin
            mode_nxt = M_ERROR;
          end else begin
            do_start = 1'b1;
          end
        end
      end
      default: begin
        do_start = 1'b1;
      end
    endcase

    // First character of a new token; the length, accumulator and digit-count registers start out cleared.
    if (do_start) begin
      mode_nxt = sd.mode;
      pend_nxt = sd.pend;
      len_nxt  = '0;
      acc_nxt  = '0;
      dcnt_nxt = '0;
      if (sd.mode == M_WORD) begin
        wbuf_nxt[0] = c;
        len_nxt = 4'd1;
      end
      if (sd.mode == M_NUM) begin
        acc_nxt  = {13'd0, c[3:0]};
        dcnt_nxt = DCW'(1);
      end
      if (sd.emit) begin
        tok_nxt[n] = sd.tok;
        n = n + 2'd1;
      end
    end

    // End of text: flush whatever is still pending, then the end token.
    if (eot) begin
      case (mode_nxt)
        M_WORD: begin
          tok_nxt[n] = word_tok(wbuf_nxt, len_nxt);
          n = n + 2'd1;
        end
        M_NUM: begin
          tok_nxt[n] = tok_number(acc_nxt);
          n = n + 2'd1;
        end
        M_OP: begin
          tok_nxt[n] = op_single(pend_nxt);
          n = n + 2'd1;
        end
        default: begin
        end
      endcase
      tok_nxt[n] = tok_kind(K_END);
      n = n + 2'd1;
      mode_nxt = M_IDLE;
      pend_nxt = P_NONE;
      len_nxt  = '0;
      acc_nxt  = '0;
      dcnt_nxt = '0;
    end

    ntok_nxt = n;
  end

  // Outputs: handshakes and the token at the read position.
  always_comb begin
    tok_t cur;
    cur = (rd_r == 2'd3) ? '0 : slot_r[rd_r];
    out_ch.valid        = rd_r != num_r;
    out_ch.token_kind   = cur.kind;
    out_ch.number_value = cur.num;
    out_ch.name_low     = cur.lo;
    out_ch.name_high    = cur.hi;
    out_ch.name_length  = cur.len;
    out_ch.error_code   = cur.err;
    out_ch.last_of_run  = out_last;
    // A new character may enter as the last stored token leaves.
    in_ch.ready = (rd_r == num_r) || (out_ch.ready && out_last);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      pend_r <= P_NONE;
      len_r  <= '0;
      acc_r  <= '0;
      dcnt_r <= '0;
      num_r  <= '0;
      rd_r   <= '0;
    end else if (in_fire) begin
      mode_r <= mode_nxt;
      pend_r <= pend_nxt;
      len_r  <= len_nxt;
      acc_r  <= acc_nxt;
      dcnt_r <= dcnt_nxt;
      num_r  <= ntok_nxt;
      rd_r   <= '0;
    end else if (out_fire) begin
      rd_r <= rd_r + 2'd1;
    end
  end

  // Payload registers: word characters and stored tokens.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      wbuf_r <= wbuf_nxt;
      for (int i = 0; i < 3; i++) begin
        slot_r[i] <= tok_nxt[i];
      end
    end
  end

endmodule
